[rtl/core/bra_pkg.sv]
// Shared constants and control types for the bitmap range allocator.
`default_nettype none
package bra_pkg;
	localparam int MAP_BITS  = 1024;
	localparam int WORD_BITS = 32;
	localparam int NUM_WORDS = MAP_BITS / WORD_BITS;
	localparam int ADDR_W    = $clog2(NUM_WORDS);
	localparam int OFF_W     = $clog2(WORD_BITS);
	localparam int POS_W     = 11;
	localparam int WIDX_W    = POS_W - OFF_W;
	localparam int KIND_W    = 3;

	localparam logic [KIND_W-1:0] KIND_SET      = 3'd0;
	localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_FIND_SET = 3'd2;
	localparam logic [KIND_W-1:0] KIND_FIND_RUN = 3'd3;
	localparam logic [KIND_W-1:0] KIND_ALLOC    = 3'd4;

	typedef struct packed {
		logic load;
		logic fail;
		logic rd;
		logic wr_step;
		logic scan_step;
		logic out_load;
	} bra_cmd_t;

	typedef struct packed {
		logic is_alloc;
		logic is_write;
		logic trivial_nop;
		logic trivial_fail;
		logic done_hit;
		logic done_miss;
		logic reread;
		logic wr_last;
	} bra_status_t;
endpackage
`default_nettype wire

[rtl/core/bra_if.sv]
// Command and result channel interfaces of the bitmap range allocator.
`default_nettype none
interface bra_in_if import bra_pkg::*;;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [POS_W-1:0]  start_req;
	logic [POS_W-1:0]  stop;
	logic [POS_W-1:0]  length;
	modport source (output valid, kind, start_req, stop, length, input ready);
	modport sink (input valid, kind, start_req, stop, length, output ready);
endinterface

interface bra_out_if import bra_pkg::*;;
	logic             valid;
	logic             ready;
	logic [POS_W-1:0] position;
	logic             found;
	modport source (output valid, position, found, input ready);
	modport sink (input valid, position, found, output ready);
endinterface
`default_nettype wire

[rtl/core/bra_datapath.sv]
// Bitmap word memory, scan cursor and range logic of the allocator.
`default_nettype none
module bra_datapath import bra_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bra_cmd_t          cmd,
	input  wire logic              wmode,
	input  wire logic [KIND_W-1:0] in_kind,
	input  wire logic [POS_W-1:0]  in_start,
	input  wire logic [POS_W-1:0]  in_stop,
	input  wire logic [POS_W-1:0]  in_length,
	output bra_status_t            st,
	output logic [POS_W-1:0]       position,
	output logic                   found
);
	logic [WORD_BITS-1:0] mem_q [NUM_WORDS];
	logic [NUM_WORDS-1:0] valid_q;
	logic [WORD_BITS-1:0] rd_q;
	logic                 rdv_q;
	logic [KIND_W-1:0]    kind_q;
	logic [POS_W-1:0]     lo_q, hi_q, need_q, cursor_q, run_q, pos_q;
	logic                 hit_q;

	logic [ADDR_W-1:0]    addr;
	logic [WIDX_W-1:0]    cur_word;
	logic [POS_W-1:0]     word_end, p, p1, e, lo_sat, hi_sat;
	logic [WORD_BITS-1:0] word, lower, upper, s, wmask, wdata;
	logic [OFF_W-1:0]     ffs;
	logic                 any_s, blk, last, fit, find_set;
	logic [POS_W:0]       run_end;

	assign addr     = cursor_q[OFF_W+ADDR_W-1:OFF_W];
	assign cur_word = cursor_q[POS_W-1:OFF_W];
	assign word_end = {cur_word + WIDX_W'(1), OFF_W'(0)};
	assign word     = rdv_q ? rd_q : '0;
	assign lower    = {WORD_BITS{1'b1}} << cursor_q[OFF_W-1:0];
	assign upper    = (hi_q[POS_W-1:OFF_W] == cur_word) ?
		~({WORD_BITS{1'b1}} << hi_q[OFF_W-1:0]) : {WORD_BITS{1'b1}};
	assign s        = word & lower;
	assign lo_sat   = (in_start > POS_W'(MAP_BITS)) ? POS_W'(MAP_BITS) : in_start;
	assign hi_sat   = (in_stop > POS_W'(MAP_BITS)) ? POS_W'(MAP_BITS) : in_stop;

	always_comb begin
		ffs = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (s[i]) begin
				ffs = OFF_W'(i);
			end
		end
	end

	assign any_s    = |s;
	assign p        = {cur_word, ffs};
	assign p1       = p + POS_W'(1);
	assign blk      = any_s && (p < hi_q);
	assign last     = word_end >= hi_q;
	assign e        = blk ? p : (last ? hi_q : word_end);
	assign run_end  = {1'b0, run_q} + {1'b0, need_q};
	assign fit      = run_end <= {1'b0, e};
	assign find_set = kind_q == KIND_FIND_SET;
	assign wmask    = lower & upper;
	assign wdata    = (kind_q == KIND_CLEAR) ? (word & ~wmask) : (word | wmask);

	always_comb begin
		st.is_alloc     = kind_q == KIND_ALLOC;
		st.is_write     = (kind_q == KIND_SET) || (kind_q == KIND_CLEAR);
		st.trivial_nop  = !(st.is_write || find_set || (kind_q == KIND_FIND_RUN) ||
			st.is_alloc) || (st.is_write && (lo_q >= hi_q));
		st.trivial_fail = (find_set || (kind_q == KIND_FIND_RUN) || st.is_alloc) &&
			((lo_q >= hi_q) || (!find_set && (need_q == '0)));
		st.done_hit     = find_set ? blk : fit;
		st.done_miss    = find_set ? (!blk && last) : (!fit && (blk ? (p1 == hi_q) : last));
		st.reread       = !blk || (ffs == {OFF_W{1'b1}});
		st.wr_last      = last;
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_q <= mem_q[addr];
		end
		if (cmd.wr_step) begin
			mem_q[addr] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rdv_q   <= 1'b0;
		end else begin
			if (cmd.rd) begin
				rdv_q <= valid_q[addr];
			end
			if (cmd.wr_step) begin
				valid_q[addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q   <= in_kind;
			lo_q     <= lo_sat;
			hi_q     <= hi_sat;
			need_q   <= in_length;
			cursor_q <= lo_sat;
			run_q    <= lo_sat;
			pos_q    <= '0;
			hit_q    <= 1'b0;
		end else if (cmd.fail) begin
			pos_q <= hi_q;
			hit_q <= 1'b0;
		end else if (cmd.wr_step) begin
			cursor_q <= word_end;
		end else if (cmd.scan_step && !wmode) begin
			if (find_set) begin
				if (blk) begin
					pos_q <= p;
					hit_q <= 1'b1;
				end else if (last) begin
					pos_q <= hi_q;
				end else begin
					cursor_q <= word_end;
				end
			end else if (fit) begin
				pos_q <= run_q;
				hit_q <= 1'b1;
				if (st.is_alloc) begin
					lo_q     <= run_q;
					hi_q     <= run_end[POS_W-1:0];
					cursor_q <= run_q;
				end
			end else if (blk) begin
				run_q    <= p1;
				cursor_q <= p1;
				if (p1 == hi_q) begin
					pos_q <= hi_q;
				end
			end else if (last) begin
				pos_q <= hi_q;
			end else begin
				cursor_q <= word_end;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			position <= pos_q;
			found    <= hit_q;
		end
	end
endmodule
`default_nettype wire

[rtl/core/bra_ctrl.sv]
// Command sequencer of the bitmap range allocator.
`default_nettype none
module bra_ctrl import bra_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        out_ready,
	input  wire bra_status_t st,
	output bra_cmd_t         cmd,
	output logic             wmode,
	output logic             in_ready,
	output logic             out_valid
);
	typedef enum logic [2:0] {IDLE, CHECK, READ, EVAL, FINISH} state_t;

	state_t state_q;
	logic   wmode_q, out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = state_q == IDLE;
	assign out_valid = out_valid_q;
	assign wmode     = wmode_q;

	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == IDLE) && in_valid;
		cmd.fail      = (state_q == CHECK) && !st.trivial_nop && st.trivial_fail;
		cmd.rd        = state_q == READ;
		cmd.wr_step   = (state_q == EVAL) && wmode_q;
		cmd.scan_step = (state_q == EVAL) && !wmode_q;
		cmd.out_load  = (state_q == FINISH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			wmode_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (in_valid) begin
						state_q <= CHECK;
					end
				end
				CHECK: begin
					wmode_q <= st.is_write;
					if (st.trivial_nop || st.trivial_fail) begin
						state_q <= FINISH;
					end else begin
						state_q <= READ;
					end
				end
				READ: begin
					state_q <= EVAL;
				end
				EVAL: begin
					if (wmode_q) begin
						state_q <= st.wr_last ? FINISH : READ;
					end else if (st.done_hit) begin
						if (st.is_alloc) begin
							wmode_q <= 1'b1;
							state_q <= READ;
						end else begin
							state_q <= FINISH;
						end
					end else if (st.done_miss) begin
						state_q <= FINISH;
					end else if (st.reread) begin
						state_q <= READ;
					end
				end
				FINISH: begin
					if (out_free) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

[rtl/core/bitmap_range_allocator_top.sv]
// Top level of the bitmap range allocator.
// The block holds a 1024-bit allocation bitmap in 32 words of 32 bits.
// Commands arrive on cmd_in; each transfer carries kind, start_req, stop
// and length. Every command yields exactly one transfer on res_out with
// position and found. Kinds set and clear a range, find the next set bit,
// find a first-fit free run, or allocate such a run.
// One command is worked at a time. A command passes through setup and
// hand-off states, plus a read and an evaluation for each bitmap word
// visited by the single memory port, plus one more evaluation for each
// marked bit that breaks a free run inside a word. An allocation then
// reads and rewrites each word that it marks.
// Reset clears the bitmap at once through one valid flag per word; the
// block takes a command in the first cycle after reset.
// The result sits in an output register. The next command is accepted
// while it waits; when the receiver stalls, that command finishes its
// work and then holds until the waiting result is taken.
`default_nettype none
module bitmap_range_allocator_top import bra_pkg::*; (
	input wire logic  clk,
	input wire logic  arst_n,
	bra_in_if.sink    cmd_in,
	bra_out_if.source res_out
);
	bra_cmd_t    cmd;
	bra_status_t st;
	logic        wmode;

	bra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd_in.valid),
		.out_ready (res_out.ready),
		.st        (st),
		.cmd       (cmd),
		.wmode     (wmode),
		.in_ready  (cmd_in.ready),
		.out_valid (res_out.valid)
	);

	bra_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.wmode     (wmode),
		.in_kind   (cmd_in.kind),
		.in_start  (cmd_in.start_req),
		.in_stop   (cmd_in.stop),
		.in_length (cmd_in.length),
		.st        (st),
		.position  (res_out.position),
		.found     (res_out.found)
	);
endmodule
`default_nettype wire

[bench/bitmap_range_allocator_top_test.sv]
// Self-checking bench for the bitmap range allocator: directed and random commands against a bitmap model.
module bitmap_range_allocator_top_test;
	import bra_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [POS_W-1:0]  start_req;
		logic [POS_W-1:0]  stop;
		logic [POS_W-1:0]  length;
	} command_t;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic             found;
	} answer_t;

	localparam int STALL_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bra_in_if cmd_ch();
	bra_out_if res_ch();

	bitmap_range_allocator_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_in(cmd_ch.sink),
		.res_out(res_ch.source)
	);

	always #5 clk = ~clk;

	bit       shadow_map [MAP_BITS];
	command_t pending_cmds[$];
	answer_t  expected_answers[$];
	int       send_idle_pct = 0;
	int       recv_idle_pct = 0;
	int       recv_hold = 0;
	bit       send_pause = 1'b0;
	int       errors = 0;
	int       quiet_cycles = 0;

	function automatic int saturate(logic [POS_W-1:0] v);
		return (v > MAP_BITS) ? MAP_BITS : int'(v);
	endfunction

	function automatic answer_t predict_answer(command_t c);
		int lo;
		int hi;
		int need;
		int run_start;
		int run_len;
		answer_t a;
		lo = saturate(c.start_req);
		hi = saturate(c.stop);
		need = int'(c.length);
		a = '0;
		case (c.kind)
			KIND_SET, KIND_CLEAR: begin
				for (int i = lo; i < hi; i++)
					shadow_map[i] = (c.kind == KIND_SET);
			end
			KIND_FIND_SET: begin
				a.position = POS_W'(hi);
				for (int i = lo; i < hi; i++) begin
					if (shadow_map[i]) begin
						a.position = POS_W'(i);
						a.found = 1'b1;
						break;
					end
				end
			end
			KIND_FIND_RUN, KIND_ALLOC: begin
				a.position = POS_W'(hi);
				run_start = lo;
				run_len = 0;
				for (int i = lo; i < hi; i++) begin
					if (shadow_map[i]) begin
						run_start = i + 1;
						run_len = 0;
					end else begin
						run_len++;
						if (run_len == need) begin
							a.position = POS_W'(run_start);
							a.found = 1'b1;
							break;
						end
					end
				end
				if (a.found && c.kind == KIND_ALLOC) begin
					for (int i = run_start; i < run_start + need; i++)
						shadow_map[i] = 1'b1;
				end
			end
			default: ;
		endcase
		return a;
	endfunction

	function automatic logic [POS_W-1:0] random_limit();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return POS_W'($urandom_range(0, MAP_BITS));
		else if (r < 92)
			return POS_W'($urandom_range(MAP_BITS, 2047));
		return POS_W'($urandom_range(0, 2047));
	endfunction

	function automatic command_t random_command();
		command_t c;
		int r;
		r = $urandom_range(0, 99);
		c.start_req = random_limit();
		c.stop = random_limit();
		if ($urandom_range(0, 3) != 0 && c.start_req > c.stop) begin
			c.start_req = c.stop;
			c.stop = random_limit();
		end
		if (r < 14)
			c.kind = KIND_SET;
		else if (r < 34)
			c.kind = KIND_CLEAR;
		else if (r < 52)
			c.kind = KIND_FIND_SET;
		else if (r < 70)
			c.kind = KIND_FIND_RUN;
		else if (r < 97)
			c.kind = KIND_ALLOC;
		else
			c.kind = KIND_W'($urandom_range(5, 7));
		if (c.kind == KIND_SET && $urandom_range(0, 1))
			c.stop = POS_W'((c.start_req + $urandom_range(0, 40)) & 11'h7ff);
		if ($urandom_range(0, 9) < 8)
			c.length = POS_W'($urandom_range(0, 48));
		else
			c.length = POS_W'($urandom_range(0, 2047));
		return c;
	endfunction

	function automatic command_t make_command(logic [KIND_W-1:0] k, int s, int e, int n);
		command_t c;
		c.kind = k;
		c.start_req = POS_W'(s);
		c.stop = POS_W'(e);
		c.length = POS_W'(n);
		return c;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			cmd_ch.kind <= '0;
			cmd_ch.start_req <= '0;
			cmd_ch.stop <= '0;
			cmd_ch.length <= '0;
		end else if (!cmd_ch.valid || cmd_ch.ready) begin
			if (pending_cmds.size() > 0 && !send_pause
					&& $urandom_range(0, 99) >= send_idle_pct) begin
				command_t c;
				c = pending_cmds.pop_front();
				expected_answers.push_back(predict_answer(c));
				cmd_ch.valid <= 1'b1;
				cmd_ch.kind <= c.kind;
				cmd_ch.start_req <= c.start_req;
				cmd_ch.stop <= c.stop;
				cmd_ch.length <= c.length;
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else if (recv_hold > 0) begin
			recv_hold <= recv_hold - 1;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				if (expected_answers.size() == 0) begin
					$display("%0t: unexpected result position=%0d found=%0b",
						$time, res_ch.position, res_ch.found);
					errors++;
				end else begin
					answer_t e;
					e = expected_answers.pop_front();
					if (e.position !== res_ch.position) begin
						$display("%0t: position mismatch expected %0d actual %0d",
							$time, e.position, res_ch.position);
						errors++;
					end
					if (e.found !== res_ch.found) begin
						$display("%0t: found mismatch expected %0b actual %0b",
							$time, e.found, res_ch.found);
						errors++;
					end
				end
			end
			if ((res_ch.valid && res_ch.ready) || (cmd_ch.valid && cmd_ch.ready)
					|| (expected_answers.size() == 0 && pending_cmds.size() == 0))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic wait_drained();
		while (pending_cmds.size() > 0 || cmd_ch.valid || expected_answers.size() > 0)
			@(posedge clk);
	endtask

	task automatic queue_random(int n);
		repeat (n) pending_cmds.push_back(random_command());
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		pending_cmds.push_back(make_command(KIND_FIND_SET, 0, 1024, 0));
		pending_cmds.push_back(make_command(KIND_FIND_RUN, 0, 2047, 1024));
		pending_cmds.push_back(make_command(KIND_ALLOC, 0, 1024, 0));
		pending_cmds.push_back(make_command(KIND_ALLOC, 0, 1024, 1));
		pending_cmds.push_back(make_command(KIND_ALLOC, 0, 1024, 31));
		pending_cmds.push_back(make_command(KIND_ALLOC, 5, 100, 40));
		pending_cmds.push_back(make_command(KIND_SET, 1023, 2047, 0));
		pending_cmds.push_back(make_command(KIND_FIND_SET, 33, 1024, 0));
		pending_cmds.push_back(make_command(KIND_FIND_SET, 500, 400, 0));
		pending_cmds.push_back(make_command(KIND_FIND_RUN, 2047, 2047, 5));
		pending_cmds.push_back(make_command(KIND_ALLOC, 0, 1024, 2047));
		pending_cmds.push_back(make_command(KIND_SET, 200, 100, 0));
		pending_cmds.push_back(make_command(KIND_CLEAR, 0, 2047, 0));
		pending_cmds.push_back(make_command(KIND_ALLOC, 0, 2047, 1024));
		pending_cmds.push_back(make_command(KIND_FIND_SET, 0, 1024, 0));
		pending_cmds.push_back(make_command(KIND_FIND_RUN, 0, 1024, 1));
		pending_cmds.push_back(make_command(KIND_CLEAR, 64, 96, 0));
		pending_cmds.push_back(make_command(KIND_FIND_RUN, 0, 1024, 32));
		pending_cmds.push_back(make_command(KIND_W'(5), 1, 2, 3));
		pending_cmds.push_back(make_command(KIND_W'(6), 2047, 2047, 2047));
		pending_cmds.push_back(make_command(KIND_W'(7), 0, 0, 0));
		pending_cmds.push_back(make_command(KIND_CLEAR, 0, 1024, 0));
		wait_drained();

		send_idle_pct = 29;
		recv_idle_pct = 50;
		queue_random(600);
		wait_drained();

		send_idle_pct = 50;
		recv_idle_pct = 29;
		recv_hold = 400;
		queue_random(700);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random(700);
		repeat (200) @(posedge clk);
		send_pause = 1'b1;
		while (cmd_ch.valid || expected_answers.size() > 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		send_pause = 1'b0;
		wait_drained();

		repeat (100) @(posedge clk);
		if (errors == 0 && expected_answers.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
